@@ design/mhpq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

    localparam int DEPTH    = 64;
    localparam int KEY_BITS = 32;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int CHILD_W  = ADDR_W + 2;
    localparam int SLOT_W   = 10;
    localparam int OUT_KEY_W = 32;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DEC    = 2'd1;
    localparam logic [1:0] REQ_INC    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DEC    = 2'd1,
        OP_INC    = 2'd2,
        OP_BAD    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [KEY_BITS-1:0] key;
        logic [SLOT_W-1:0]   slot;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             busy;
    } back_stat_t;

endpackage

`default_nettype wire

@@ design/mhpq_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Accepts requests, classifies them and holds them in a two-entry queue.
module mhpq_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          valid,
    output logic                               ready,
    input  wire logic [1:0]                    req_type,
    input  wire logic [31:0]                   key_in,
    input  wire logic [mhpq_pkg::SLOT_W-1:0]   slot,
    output logic                               cmd_valid,
    input  wire logic                          cmd_ready,
    output mhpq_pkg::cmd_t                     cmd
);

    mhpq_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     level_reg, level_next;
    logic           push, pop;
    mhpq_pkg::cmd_t in_cmd;

    always_comb
    begin
        unique case (req_type)
            mhpq_pkg::REQ_INSERT: in_cmd.op = mhpq_pkg::OP_INSERT;
            mhpq_pkg::REQ_DEC:    in_cmd.op = mhpq_pkg::OP_DEC;
            mhpq_pkg::REQ_INC:    in_cmd.op = mhpq_pkg::OP_INC;
            default:              in_cmd.op = mhpq_pkg::OP_BAD;
        endcase
        in_cmd.key  = key_in[mhpq_pkg::KEY_BITS-1:0];
        in_cmd.slot = slot;
    end

    assign ready     = (level_reg != 2'd2);
    assign cmd_valid = (level_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = valid && ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        level_next  = level_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

`default_nettype wire

@@ design/mhpq_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Heap engine: key memory, entry count, sift sequencer and output register.
module mhpq_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_ready,
    input  wire mhpq_pkg::cmd_t              cmd,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [31:0]                      out_key,
    output logic [mhpq_pkg::SLOT_W-1:0]      out_slot,
    output logic [1:0]                       out_status,
    output logic                             out_last,
    output mhpq_pkg::back_stat_t             stat
);

    localparam int KB = mhpq_pkg::KEY_BITS;
    localparam int AW = mhpq_pkg::ADDR_W;
    localparam int CW = mhpq_pkg::CNT_W;
    localparam int HW = mhpq_pkg::CHILD_W;
    localparam int SW = mhpq_pkg::SLOT_W;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CHECK  = 11'b00000000010,
        S_LOAD   = 11'b00000000100,
        S_LOADED = 11'b00000001000,
        S_UP     = 11'b00000010000,
        S_UP_CMP = 11'b00000100000,
        S_DN     = 11'b00001000000,
        S_DN_L   = 11'b00010000000,
        S_DN_R   = 11'b00100000000,
        S_DN_CMP = 11'b01000000000,
        S_FINAL  = 11'b10000000000
    } state_t;

    logic [KB-1:0] mem [mhpq_pkg::DEPTH];
    logic [KB-1:0] rdata_reg;

    state_t            state_reg, state_next;
    mhpq_pkg::op_t     op_reg, op_next;
    logic [KB-1:0]     key_reg, key_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [KB-1:0]     lkey_reg, lkey_next;
    logic [KB-1:0]     pkey_reg, pkey_next;
    logic [AW-1:0]     ppos_reg, ppos_next;

    logic              ovalid_reg, ovalid_next;
    logic [31:0]       okey_reg, okey_next;
    logic [SW-1:0]     oslot_reg, oslot_next;
    logic [1:0]        ostat_reg, ostat_next;
    logic              olast_reg, olast_next;

    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [KB-1:0]     wr_data;
    logic              out_free;
    logic [HW-1:0]     left, right;
    logic [HW-1:0]     count_ext;
    logic [AW-1:0]     parent;

    assign out_free  = !ovalid_reg || out_ready;
    assign left      = {1'b0, pos_reg, 1'b1};
    assign right     = left + HW'(1);
    assign count_ext = HW'(count_reg);
    assign parent    = (pos_reg - AW'(1)) >> 1;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        slot_next   = slot_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        lkey_next   = lkey_reg;
        pkey_next   = pkey_reg;
        ppos_next   = ppos_reg;
        ovalid_next = ovalid_reg && !out_ready;
        okey_next   = okey_reg;
        oslot_next  = oslot_reg;
        ostat_next  = ostat_reg;
        olast_next  = olast_reg;
        rd_en       = 1'b0;
        rd_addr     = pos_reg;
        wr_en       = 1'b0;
        wr_addr     = pos_reg;
        wr_data     = key_reg;
        cmd_ready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    op_next    = cmd.op;
                    key_next   = cmd.key;
                    slot_next  = cmd.slot;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (op_reg == mhpq_pkg::OP_INSERT
                             && count_reg != CW'(mhpq_pkg::DEPTH))
                begin
                    pos_next   = count_reg[AW-1:0];
                    count_next = count_reg + CW'(1);
                    state_next = S_UP;
                end
                else if (op_reg == mhpq_pkg::OP_DEC || op_reg == mhpq_pkg::OP_INC)
                begin
                    if (slot_reg < SW'(count_reg))
                    begin
                        pos_next   = slot_reg[AW-1:0];
                        state_next = S_LOAD;
                    end
                    else if (out_free)
                    begin
                        ovalid_next = 1'b1;
                        okey_next   = '0;
                        oslot_next  = slot_reg;
                        ostat_next  = mhpq_pkg::ST_RANGE;
                        olast_next  = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else if (out_free)
                begin
                    // Full heap or unknown request.
                    ovalid_next = 1'b1;
                    olast_next  = 1'b1;
                    oslot_next  = '0;
                    if (op_reg == mhpq_pkg::OP_INSERT)
                    begin
                        okey_next  = 32'(key_reg);
                        ostat_next = mhpq_pkg::ST_FULL;
                    end
                    else
                    begin
                        okey_next  = '0;
                        ostat_next = mhpq_pkg::ST_RANGE;
                    end
                    state_next = S_IDLE;
                end
            end
            S_LOAD:
            begin
                rd_en      = 1'b1;
                state_next = S_LOADED;
            end
            S_LOADED:
            begin
                key_next = rdata_reg;
                if (op_reg == mhpq_pkg::OP_DEC)
                begin
                    if (rdata_reg == '0)
                    begin
                        if (out_free)
                        begin
                            ovalid_next = 1'b1;
                            okey_next   = '0;
                            oslot_next  = SW'(pos_reg);
                            ostat_next  = mhpq_pkg::ST_SAT;
                            olast_next  = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    else
                    begin
                        key_next   = rdata_reg - KB'(1);
                        state_next = S_UP;
                    end
                end
                else
                begin
                    if (rdata_reg == '1)
                    begin
                        if (out_free)
                        begin
                            ovalid_next = 1'b1;
                            okey_next   = 32'(rdata_reg);
                            oslot_next  = SW'(pos_reg);
                            ostat_next  = mhpq_pkg::ST_SAT;
                            olast_next  = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    else
                    begin
                        key_next   = rdata_reg + KB'(1);
                        state_next = S_DN;
                    end
                end
            end
            S_UP:
            begin
                if (pos_reg == '0)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = parent;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (rdata_reg <= key_reg)
                begin
                    state_next = S_FINAL;
                end
                else if (out_free)
                begin
                    wr_en       = 1'b1;
                    wr_data     = rdata_reg;
                    ovalid_next = 1'b1;
                    okey_next   = 32'(rdata_reg);
                    oslot_next  = SW'(pos_reg);
                    ostat_next  = mhpq_pkg::ST_OK;
                    olast_next  = 1'b0;
                    pos_next    = parent;
                    state_next  = S_UP;
                end
            end
            S_DN:
            begin
                if (left >= count_ext)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = left[AW-1:0];
                    state_next = S_DN_L;
                end
            end
            S_DN_L:
            begin
                lkey_next = rdata_reg;
                if (right < count_ext)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = right[AW-1:0];
                    state_next = S_DN_R;
                end
                else
                begin
                    pkey_next  = rdata_reg;
                    ppos_next  = left[AW-1:0];
                    state_next = S_DN_CMP;
                end
            end
            S_DN_R:
            begin
                // The left child wins ties.
                if (rdata_reg < lkey_reg)
                begin
                    pkey_next = rdata_reg;
                    ppos_next = right[AW-1:0];
                end
                else
                begin
                    pkey_next = lkey_reg;
                    ppos_next = left[AW-1:0];
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (key_reg <= pkey_reg)
                begin
                    state_next = S_FINAL;
                end
                else if (out_free)
                begin
                    wr_en       = 1'b1;
                    wr_data     = pkey_reg;
                    ovalid_next = 1'b1;
                    okey_next   = 32'(pkey_reg);
                    oslot_next  = SW'(pos_reg);
                    ostat_next  = mhpq_pkg::ST_OK;
                    olast_next  = 1'b0;
                    pos_next    = ppos_reg;
                    state_next  = S_DN;
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    wr_en       = 1'b1;
                    ovalid_next = 1'b1;
                    okey_next   = 32'(key_reg);
                    oslot_next  = SW'(pos_reg);
                    ostat_next  = mhpq_pkg::ST_OK;
                    olast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        slot_reg  <= slot_next;
        pos_reg   <= pos_next;
        lkey_reg  <= lkey_next;
        pkey_reg  <= pkey_next;
        ppos_reg  <= ppos_next;
        okey_reg  <= okey_next;
        oslot_reg <= oslot_next;
        ostat_reg <= ostat_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_key    = okey_reg;
    assign out_slot   = oslot_reg;
    assign out_status = ostat_reg;
    assign out_last   = olast_reg;
    assign stat.count = count_reg;
    assign stat.busy  = (state_reg != S_IDLE);

endmodule

`default_nettype wire

@@ design/min_heap_priority_queue_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Binary min-heap priority queue of 64 unsigned 32-bit keys. Each request
// inserts a key, or decrements or increments the key at a heap index, and the
// heap order is then restored by sifting along one root-to-leaf path. Every
// key that moves is reported as one result transfer with its new index, and a
// final transfer with last set gives the request's own key at its final place;
// rejected and saturated requests give one transfer. The heap engine takes
// a request and checks it, reads the key of a decrement or increment, reads
// and compares each parent on a sift-up or the children of each level on a
// sift-down, and writes the final key where the sift stops. A result that
// waits for the receiver holds the engine in any state that must give a
// result. Each sift step reads the single-port key memory once or twice
// before it compares and writes. A two-entry request queue lets new requests
// transfer in while the heap engine works, and the result register lets the
// engine read ahead while one result waits to be taken.
module min_heap_priority_queue_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  req_type,
    input  wire logic [31:0]                 key_in,
    input  wire logic [9:0]                  slot,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [31:0]                      moved_key,
    output logic [9:0]                       new_slot,
    output logic [1:0]                       status,
    output logic                             last
);

    logic                 cmd_valid;
    logic                 cmd_ready;
    mhpq_pkg::cmd_t       cmd;
    mhpq_pkg::back_stat_t stat;

    // Front end: classifies requests and queues them.
    mhpq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (in_valid),
        .ready     (in_ready),
        .req_type  (req_type),
        .key_in    (key_in),
        .slot      (slot),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Back end: key memory and the sift sequencer.
    mhpq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_key    (moved_key),
        .out_slot   (new_slot),
        .out_status (status),
        .out_last   (last),
        .stat       (stat)
    );

    // The entry count never goes past the heap size.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= mhpq_pkg::CNT_W'(mhpq_pkg::DEPTH))
        else $error("entry count beyond heap size");

    // A heap-full result is only given when the heap really is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == mhpq_pkg::ST_FULL
        |-> stat.count == mhpq_pkg::CNT_W'(mhpq_pkg::DEPTH))
        else $error("heap full reported on a heap with room");

    // Only moves within a sift come without last, and they are always ok.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> status == mhpq_pkg::ST_OK && stat.busy)
        else $error("intermediate result with bad status or idle engine");

    // A waiting result keeps its key.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(moved_key))
        else $error("result dropped or changed while stalled");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    // Clock, reset and the ports of the block under test.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = mhpq_pkg::REQ_INSERT;
    logic [31:0] key_in = '0;
    logic [9:0]  slot = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] moved_key;
    logic [9:0]  new_slot;
    logic [1:0]  status;
    logic        last;

    // One expected result transfer, as the block should present it.
    typedef struct packed {
        logic [31:0] key;
        logic [9:0]  pos;
        logic [1:0]  st;
        logic        fin;
    } heap_move_t;

    // The testbench's own copy of the heap, kept in step with the block.
    logic [31:0] shadow_heap [mhpq_pkg::DEPTH];
    int          shadow_count;
    heap_move_t  pending_moves [$];

    int errors;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles = 0;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;

    min_heap_priority_queue_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .key_in    (key_in),
        .slot      (slot),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .moved_key (moved_key),
        .new_slot  (new_slot),
        .status    (status),
        .last      (last)
    );

    always #6 clk = ~clk;

    // Queue one expected transfer.
    function automatic void note_move(logic [31:0] k, int p, logic [1:0] s, logic f);
        heap_move_t m;
        m.key = k;
        m.pos = p[9:0];
        m.st  = s;
        m.fin = f;
        pending_moves = {pending_moves, m};
    endfunction

    // Sift-up from index p; every parent that drops down is reported at its
    // new index, and the moving key is reported last at its resting place.
    function automatic void shadow_sift_up(int p);
        logic [31:0] k;
        int          parent;
        k = shadow_heap[p];
        while (p > 0) begin
            parent = (p - 1) / 2;
            if (shadow_heap[parent] <= k)
                break;
            shadow_heap[p] = shadow_heap[parent];
            note_move(shadow_heap[p], p, mhpq_pkg::ST_OK, 1'b0);
            p = parent;
        end
        shadow_heap[p] = k;
        note_move(k, p, mhpq_pkg::ST_OK, 1'b1);
    endfunction

    // Sift-down from index p. The left child wins ties; equal keys never swap.
    function automatic void shadow_sift_down(int p);
        logic [31:0] k;
        int          lc;
        int          rc;
        int          pick;
        k = shadow_heap[p];
        forever begin
            lc = 2 * p + 1;
            rc = 2 * p + 2;
            if (lc >= shadow_count)
                break;
            pick = lc;
            if (rc < shadow_count && shadow_heap[rc] < shadow_heap[lc])
                pick = rc;
            if (k <= shadow_heap[pick])
                break;
            shadow_heap[p] = shadow_heap[pick];
            note_move(shadow_heap[p], p, mhpq_pkg::ST_OK, 1'b0);
            p = pick;
        end
        shadow_heap[p] = k;
        note_move(k, p, mhpq_pkg::ST_OK, 1'b1);
    endfunction

    // Apply one accepted request to the shadow heap and queue its results.
    function automatic void predict_request(logic [1:0] rq, logic [31:0] k, logic [9:0] s);
        int p;
        p = s;
        if (rq == mhpq_pkg::REQ_INSERT) begin
            if (shadow_count >= mhpq_pkg::DEPTH) begin
                note_move(k, 0, mhpq_pkg::ST_FULL, 1'b1);
            end else begin
                shadow_heap[shadow_count] = k;
                shadow_count++;
                shadow_sift_up(shadow_count - 1);
            end
        end else if (rq == mhpq_pkg::OP_BAD) begin
            note_move('0, 0, mhpq_pkg::ST_RANGE, 1'b1);
        end else if (p >= shadow_count) begin
            note_move('0, p, mhpq_pkg::ST_RANGE, 1'b1);
        end else if (rq == mhpq_pkg::REQ_DEC) begin
            if (shadow_heap[p] == '0) begin
                note_move('0, p, mhpq_pkg::ST_SAT, 1'b1);
            end else begin
                shadow_heap[p] = shadow_heap[p] - 32'd1;
                shadow_sift_up(p);
            end
        end else begin
            if (shadow_heap[p] == '1) begin
                note_move('1, p, mhpq_pkg::ST_SAT, 1'b1);
            end else begin
                shadow_heap[p] = shadow_heap[p] + 32'd1;
                shadow_sift_down(p);
            end
        end
    endfunction

    // Drive one request and hold it until its transfer. The prediction is
    // made at the accepting edge so that it follows the block's own order.
    // Valid stays high after the transfer until the next request or pause.
    task automatic send_request(logic [1:0] rq, logic [31:0] k, logic [9:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        key_in   <= k;
        slot     <= s;
        do
            @(posedge clk);
        while (!in_ready);
        predict_request(rq, k, s);
    endtask

    // Wait until every expected result has been taken.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_moves.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The receiver stalls at random, per cycle, at the current rate.
    always @(posedge clk) begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Each result transfer is checked against the oldest expectation.
    always @(posedge clk) begin
        heap_move_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_moves.size() == 0) begin
                $display("%0t: unexpected result key=%h slot=%0d status=%0d last=%0b",
                         $time, moved_key, new_slot, status, last);
                errors++;
            end else begin
                want = pending_moves.pop_front();
                if (moved_key !== want.key) begin
                    $display("%0t: moved_key expected %h actual %h", $time, want.key, moved_key);
                    errors++;
                end
                if (new_slot !== want.pos) begin
                    $display("%0t: new_slot expected %0d actual %0d", $time, want.pos, new_slot);
                    errors++;
                end
                if (status !== want.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                    errors++;
                end
                if (last !== want.fin) begin
                    $display("%0t: last expected %0b actual %0b", $time, want.fin, last);
                    errors++;
                end
            end
        end
    end

    // The watchdog ends the run after a long stretch with no transfer on
    // either channel.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[min_heap_priority_queue_unit] ERROR");
            $finish;
        end
    end

    // Random key, biased toward the extremes and near-ties so that
    // saturation and equal-key cases turn up often.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(3);
            3: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // Directed part: extremes, every request kind, and the out-of-range, unknown-kind and saturation cases.
    task automatic test_directed();
        send_request(mhpq_pkg::REQ_DEC, '0, 10'd0);       // decrement on an empty heap
        send_request(mhpq_pkg::REQ_INC, '0, 10'd1023);    // increment far out of range
        send_request(mhpq_pkg::OP_BAD, '1, 10'h3FF);      // unknown request kind
        send_request(mhpq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 10'h2AA);
        send_request(mhpq_pkg::REQ_INSERT, 32'h0000_0000, 10'h155);
        send_request(mhpq_pkg::REQ_INSERT, 32'h0000_0000, 10'd0);  // equal key, no swap
        send_request(mhpq_pkg::REQ_INSERT, 32'h8000_0000, 10'd0);
        send_request(mhpq_pkg::REQ_INSERT, 32'h0000_0001, 10'd0);
        send_request(mhpq_pkg::REQ_DEC, '0, 10'd0);       // decrement of a zero key
        send_request(mhpq_pkg::REQ_INC, '0, 10'd1);       // increment of the key at index 1
        send_request(mhpq_pkg::REQ_INC, '0, 10'd0);       // sift-down from the root
        send_request(mhpq_pkg::REQ_INC, '0, 10'd0);
        send_request(mhpq_pkg::REQ_DEC, '0, 10'd4);       // decrement with no move toward the root
        send_request(mhpq_pkg::REQ_DEC, '1, 10'd3);
        send_request(mhpq_pkg::REQ_INC, '0, 10'd5);       // exactly at the count
        send_request(mhpq_pkg::REQ_INC, '0, 10'd4);
        wait_drained();   // the sender pauses until every result is in
    endtask

    // Fill to capacity, then try to insert into a full heap.
    task automatic test_full_heap();
        while (shadow_count < mhpq_pkg::DEPTH)
            send_request(mhpq_pkg::REQ_INSERT, pick_key(), 10'($urandom));
        send_request(mhpq_pkg::REQ_INSERT, 32'h1234_5678, 10'd0);
        send_request(mhpq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 10'd0);
        send_request(mhpq_pkg::REQ_DEC, '0, 10'(mhpq_pkg::DEPTH - 1));
        send_request(mhpq_pkg::REQ_INC, '0, 10'(mhpq_pkg::DEPTH));
        send_request(mhpq_pkg::REQ_INC, '0, 10'd0);
    endtask

    // Mostly in-range decrements and increments, with inserts, out-of-range
    // indexes and unknown kinds as noise.
    task automatic test_random(int n);
        int          sel;
        logic [1:0]  rq;
        logic [9:0]  s;
        repeat (n) begin
            sel = $urandom_range(99);
            s = 10'($urandom);
            if (sel < 20)
                rq = mhpq_pkg::REQ_INSERT;
            else if (sel < 25)
                rq = mhpq_pkg::OP_BAD;
            else begin
                rq = (sel < 62) ? mhpq_pkg::REQ_DEC : mhpq_pkg::REQ_INC;
                if (sel % 7 != 0 && shadow_count > 0)
                    s = 10'($urandom_range(shadow_count - 1));
            end
            send_request(rq, pick_key(), s);
        end
    endtask

    initial begin
        errors = 0;
        shadow_count = 0;
        send_idle_pct = 35;
        recv_idle_pct = 48;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_heap();
        test_random(60);
        send_idle_pct = 48;
        recv_idle_pct = 35;
        test_random(60);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(60);

        wait_drained();
        if (errors == 0)
            $display("[min_heap_priority_queue_unit] OK");
        else
            $display("[min_heap_priority_queue_unit] ERROR");
        $finish;
    end
endmodule
